@@ sv/aat_pkg.sv @@
// shared types and constants for the bounding box transform
package aat_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = IDX_W + 3;
    localparam int NUM_AXES  = 3;
    localparam int LATENCY   = 5;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [REG_W-1:0]         t_reg;

    localparam logic [IDX_W-1:0] REG_ROW0_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_B = 3'd5;

    localparam t_reg FIX_ONE = REG_W'(1) << FRAC_BITS;

    localparam t_sum SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam t_sum SAT_LO = SUM_W'($signed(32'h8000_0000));

    function automatic t_reg reg_reset(input logic [IDX_W-1:0] idx);
        t_reg v;
        v = '0;
        unique case (idx)
            REG_ROW0_A: v = FIX_ONE;
            REG_ROW1_A: v = FIX_ONE << WORD_W;
            REG_ROW2_B: v = FIX_ONE;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // align translation to the product scale
    function automatic t_sum align_trans(input t_word t);
        return {{(SUM_W-WORD_W-FRAC_BITS){t[WORD_W-1]}}, t, {FRAC_BITS{1'b0}}};
    endfunction

    // floor to fixed point, then clamp to the word range
    function automatic t_word floor_sat(input t_sum s);
        t_sum sh;
        t_word r;
        sh = s >>> FRAC_BITS;
        if (sh > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end else if (sh < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end else begin
            r = sh[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/aabb_affine_transform.sv @@
// Axis-aligned box transform: one box enters per clock through start
// (busy never rises), passes a fixed five-stage pipeline (input register,
// 18 coefficient multipliers, per-coefficient min/max select, sum with
// translation, floor and saturate) and leaves with o_done high for exactly
// one cycle once the beat has left the last stage. The results cannot be
// held off, so the receiver must take them as they come. Each output axis
// is the min and max of all eight mapped corners in Q16.16, rounded toward
// minus infinity and saturated to 32 bits. The 3x4 matrix sits in six
// 64-bit registers at byte address 8*i; write them only while no box is
// in flight.
module aabb_affine_transform import aat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_word             i_lo_x,
    input  t_word             i_lo_y,
    input  t_word             i_lo_z,
    input  t_word             i_hi_x,
    input  t_word             i_hi_y,
    input  t_word             i_hi_z,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  t_reg              pwdata,
    output t_reg              prdata,
    output logic              pready,
    output logic              o_done,
    output t_word             o_out_lo_x,
    output t_word             o_out_lo_y,
    output t_word             o_out_lo_z,
    output t_word             o_out_hi_x,
    output t_word             o_out_hi_y,
    output t_word             o_out_hi_z
);

    t_reg             r_mat [NUM_REGS];
    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;
    logic             accept;

    logic [LATENCY-1:0] r_vld;

    t_word r_lo  [NUM_AXES];
    t_word r_hi  [NUM_AXES];
    t_prod r_p   [NUM_AXES][NUM_AXES];
    t_prod r_q   [NUM_AXES][NUM_AXES];
    t_prod r_mn  [NUM_AXES][NUM_AXES];
    t_prod r_mx  [NUM_AXES][NUM_AXES];
    t_sum  r_smin[NUM_AXES];
    t_sum  r_smax[NUM_AXES];
    t_word r_olo [NUM_AXES];
    t_word r_ohi [NUM_AXES];

    t_word coef  [NUM_AXES][NUM_AXES];
    t_word trans [NUM_AXES];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;

    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_mat[i] <= reg_reset(IDX_W'(i));
            end
        end else if (cfg_wr && (cfg_idx < IDX_W'(NUM_REGS))) begin
            r_mat[cfg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx < IDX_W'(NUM_REGS)) begin
            prdata = r_mat[cfg_idx];
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            coef[r][0] = r_mat[2*r][WORD_W-1:0];
            coef[r][1] = r_mat[2*r][REG_W-1:WORD_W];
            coef[r][2] = r_mat[2*r+1][WORD_W-1:0];
            trans[r]   = r_mat[2*r+1][REG_W-1:WORD_W];
        end
    end

    // beat tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    assign o_done = r_vld[LATENCY-1];

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo[0] <= i_lo_x;
            r_lo[1] <= i_lo_y;
            r_lo[2] <= i_lo_z;
            r_hi[0] <= i_hi_x;
            r_hi[1] <= i_hi_y;
            r_hi[2] <= i_hi_z;
        end
        for (int r = 0; r < NUM_AXES; r++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_p[r][c] <= t_prod'(coef[r][c]) * t_prod'(r_lo[c]);
                r_q[r][c] <= t_prod'(coef[r][c]) * t_prod'(r_hi[c]);
                if (r_p[r][c] < r_q[r][c]) begin
                    r_mn[r][c] <= r_p[r][c];
                    r_mx[r][c] <= r_q[r][c];
                end else begin
                    r_mn[r][c] <= r_q[r][c];
                    r_mx[r][c] <= r_p[r][c];
                end
            end
            r_smin[r] <= t_sum'(r_mn[r][0]) + t_sum'(r_mn[r][1]) + t_sum'(r_mn[r][2])
                       + align_trans(trans[r]);
            r_smax[r] <= t_sum'(r_mx[r][0]) + t_sum'(r_mx[r][1]) + t_sum'(r_mx[r][2])
                       + align_trans(trans[r]);
            r_olo[r]  <= floor_sat(r_smin[r]);
            r_ohi[r]  <= floor_sat(r_smax[r]);
        end
    end

    assign o_out_lo_x = r_olo[0];
    assign o_out_lo_y = r_olo[1];
    assign o_out_lo_z = r_olo[2];
    assign o_out_hi_x = r_ohi[0];
    assign o_out_hi_y = r_ohi[1];
    assign o_out_hi_z = r_ohi[2];

endmodule

@@ sv/aat_checker.sv @@
// port-level checks for the bounding box transform, bound to the top level
module aat_checker import aat_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              pready,
    input logic              o_done,
    input t_word             o_out_lo_x,
    input t_word             o_out_lo_y,
    input t_word             o_out_lo_z,
    input t_word             o_out_hi_x,
    input t_word             o_out_hi_y,
    input t_word             o_out_hi_z
);

    // each taken beat comes out of the pipeline with o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result missing after accepted beat");

    // no result without a taken beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_done)
        else $error("result without accepted beat");

    // the pipeline takes a box every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // bounds stay ordered on every axis
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_lo_x <= o_out_hi_x) && (o_out_lo_y <= o_out_hi_y)
                && (o_out_lo_z <= o_out_hi_z))
        else $error("min exceeds max");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);
